FILE: hdl/ovmw_pkg.sv
// ----------------------------------------------------------------------------
// ovmw_pkg
// Shared types, constants and helper functions of the voice mute write filter.
// ----------------------------------------------------------------------------
package ovmw_pkg;

    // Chip and voice geometry.
    localparam int CHIP_COUNT        = 2;
    localparam int CHANNELS_PER_CHIP = 9;
    localparam int VOICE_LIMIT       = CHIP_COUNT * CHANNELS_PER_CHIP;
    localparam int LEVEL_DEPTH       = VOICE_LIMIT * 2;
    localparam int LEVEL_AW          = $clog2(LEVEL_DEPTH);
    localparam int MUTE_AW           = $clog2(VOICE_LIMIT);
    localparam int VOICE_W           = 5;
    localparam int CH_W              = $clog2(CHANNELS_PER_CHIP);

    // Request queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Register map constants.
    localparam logic [7:0] TL_BASE_SLOT0 = 8'h40;
    localparam logic [7:0] TL_BASE_SLOT1 = 8'h43;
    localparam logic [7:0] KEEP_MASK     = 8'hC0;
    localparam logic [7:0] SILENT_BITS   = 8'h3F;

    // Request operation codes.
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_MUTE  = 1'b1
    } t_op;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SLOT0,
        BK_SLOT1
    } t_back_state;

    // Classified request as held in the queue.
    typedef struct packed {
        logic                is_mute;
        logic                chip;
        logic [7:0]          reg_addr;
        logic [7:0]          value;
        logic                store_en;
        logic                slot;
        logic [VOICE_W-1:0]  voice;
        logic [CH_W-1:0]     channel;
        logic                mute_flag;
    } t_entry;

    // Queue status seen by both sides.
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    // Result of decoding a register address against the total-level map.
    typedef struct packed {
        logic            hit;
        logic [CH_W-1:0] channel;
        logic            slot;
    } t_level_decode;

    // Operator offset of each channel within the register map.
    function automatic logic [7:0] op_offset(input logic [CH_W-1:0] ch);
        logic [7:0] off;
        unique case (ch)
            4'd0:    off = 8'd0;
            4'd1:    off = 8'd1;
            4'd2:    off = 8'd2;
            4'd3:    off = 8'd8;
            4'd4:    off = 8'd9;
            4'd5:    off = 8'd10;
            4'd6:    off = 8'd16;
            4'd7:    off = 8'd17;
            4'd8:    off = 8'd18;
            default: off = 8'd0;
        endcase
        return off;
    endfunction

    // Force the level bits to full attenuation, keeping the scaling bits.
    function automatic logic [7:0] silence(input logic [7:0] v);
        return (v & KEEP_MASK) | SILENT_BITS;
    endfunction

    // Match an address against the total-level registers of every channel.
    function automatic t_level_decode decode_level(input logic [7:0] addr);
        t_level_decode d;
        d = '0;
        for (int c = CHANNELS_PER_CHIP - 1; c >= 0; c--) begin
            if (addr == TL_BASE_SLOT0 + op_offset(CH_W'(c))) begin
                d.hit     = 1'b1;
                d.channel = CH_W'(c);
                d.slot    = 1'b0;
            end
            if (addr == TL_BASE_SLOT1 + op_offset(CH_W'(c))) begin
                d.hit     = 1'b1;
                d.channel = CH_W'(c);
                d.slot    = 1'b1;
            end
        end
        return d;
    endfunction

endpackage

FILE: hdl/ovmw_front.sv
// ----------------------------------------------------------------------------
// ovmw_front
// Accepts requests, classifies them and pushes them into the request queue.
// ----------------------------------------------------------------------------
module ovmw_front import ovmw_pkg::*; (
    input  logic               i_start,
    input  t_queue_status      i_status,
    input  logic               i_operation,
    input  logic               i_chip_select,
    input  logic [7:0]         i_register_address,
    input  logic [7:0]         i_write_value,
    input  logic [VOICE_W-1:0] i_voice_index,
    input  logic               i_mute_flag,
    output logic               o_busy,
    output logic               o_push,
    output t_entry             o_entry
);

    t_level_decode      dec;
    logic               chip_ok;
    logic               voice_ok;
    logic               accept;
    logic               mute_chip;
    logic [VOICE_W-1:0] mute_rem;
    logic [VOICE_W-1:0] write_voice;

    // Decode the register address and the voice number.
    always_comb begin
        dec       = decode_level(i_register_address);
        chip_ok   = int'(i_chip_select) < CHIP_COUNT;
        voice_ok  = int'(i_voice_index) < VOICE_LIMIT;
        mute_chip = int'(i_voice_index) >= CHANNELS_PER_CHIP;
        mute_rem  = mute_chip ? i_voice_index - VOICE_W'(CHANNELS_PER_CHIP)
                              : i_voice_index;
        write_voice = i_chip_select ? VOICE_W'(CHANNELS_PER_CHIP) + VOICE_W'(dec.channel)
                                    : VOICE_W'(dec.channel);
    end

    // Build the queue entry for either kind of request.
    always_comb begin
        o_entry           = '0;
        o_entry.is_mute   = (i_operation == OP_MUTE);
        o_entry.value     = i_write_value;
        o_entry.mute_flag = i_mute_flag;
        if (i_operation == OP_MUTE) begin
            o_entry.chip    = mute_chip;
            o_entry.voice   = i_voice_index;
            o_entry.channel = CH_W'(mute_rem);
        end else begin
            o_entry.chip     = i_chip_select;
            o_entry.reg_addr = i_register_address;
            o_entry.store_en = dec.hit && chip_ok;
            o_entry.slot     = dec.slot;
            o_entry.voice    = write_voice;
            o_entry.channel  = dec.channel;
        end
    end

    // Mute changes for voices out of range are taken and dropped here.
    assign accept = i_start && !i_status.full;
    assign o_push = accept && ((i_operation == OP_WRITE) || voice_ok);
    assign o_busy = i_status.full;

endmodule

FILE: hdl/ovmw_queue.sv
// ----------------------------------------------------------------------------
// ovmw_queue
// Short request queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module ovmw_queue import ovmw_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_entry        i_entry,
    input  logic          i_pop,
    output t_entry        o_entry,
    output t_queue_status o_status
);

    t_entry               r_slots [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0]  r_wr_ptr;
    logic [QUEUE_PW-1:0]  r_rd_ptr;
    logic [QUEUE_CW-1:0]  r_count;
    logic [QUEUE_PW-1:0]  n_wr_ptr;
    logic [QUEUE_PW-1:0]  n_rd_ptr;
    logic [QUEUE_CW-1:0]  n_count;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_entry;
        end
    end

    assign o_entry        = r_slots[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));

endmodule

FILE: hdl/ovmw_back.sv
// ----------------------------------------------------------------------------
// ovmw_back
// Carries out queued requests: level store, mute bits and result output.
// ----------------------------------------------------------------------------
module ovmw_back import ovmw_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_entry        i_entry,
    input  t_queue_status i_status,
    output logic          o_pop,
    output logic          o_strobe,
    output logic          o_chip,
    output logic [7:0]    o_register,
    output logic [7:0]    o_value,
    output logic          o_last,
    output logic          o_dual_active
);

    t_back_state          r_state;
    t_back_state          n_state;

    logic [7:0]           r_level_mem   [LEVEL_DEPTH];
    logic                 r_level_valid [LEVEL_DEPTH];
    logic [7:0]           r_rd_data;
    logic                 r_rd_valid;
    logic                 r_mute_bits   [VOICE_LIMIT];
    logic                 r_dual;

    // Mute change being replayed.
    logic [VOICE_W-1:0]   r_cur_voice;
    logic [CH_W-1:0]      r_cur_channel;
    logic                 r_cur_chip;
    logic                 r_cur_mute;

    logic                 r_strobe;
    logic                 r_chip;
    logic [7:0]           r_register;
    logic [7:0]           r_value;
    logic                 r_last;
    logic                 r_dual_out;

    // Control decided by the sequencer outputs block.
    logic                 pop;
    logic                 lvl_we;
    logic [LEVEL_AW-1:0]  lvl_waddr;
    logic [LEVEL_AW-1:0]  rd_addr;
    logic                 mute_we;
    logic                 capture;
    logic                 load;
    logic                 ld_chip;
    logic [7:0]           ld_register;
    logic [7:0]           ld_value;
    logic                 ld_last;
    logic                 n_dual;
    logic [7:0]           stored_level;

    // Stored level of the word just read; never-written entries read as zero.
    assign stored_level = r_rd_valid ? r_rd_data : 8'h00;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_status.empty && i_entry.is_mute) begin
                    n_state = BK_SLOT0;
                end
            end
            BK_SLOT0: n_state = BK_SLOT1;
            BK_SLOT1: n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        pop         = 1'b0;
        lvl_we      = 1'b0;
        lvl_waddr   = LEVEL_AW'({i_entry.voice, i_entry.slot});
        rd_addr     = LEVEL_AW'({r_cur_voice, 1'b1});
        mute_we     = 1'b0;
        capture     = 1'b0;
        load        = 1'b0;
        ld_chip     = r_cur_chip;
        ld_register = TL_BASE_SLOT0 + op_offset(r_cur_channel);
        ld_value    = stored_level;
        ld_last     = 1'b0;
        n_dual      = r_dual;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_status.empty) begin
                    pop = 1'b1;
                    if (i_entry.is_mute) begin
                        // Record the mute bit and fetch the slot 0 level.
                        mute_we = 1'b1;
                        capture = 1'b1;
                        rd_addr = LEVEL_AW'({i_entry.voice, 1'b0});
                    end else begin
                        // Plain or total-level write: one result.
                        lvl_we      = i_entry.store_en;
                        load        = 1'b1;
                        ld_chip     = i_entry.chip;
                        ld_register = i_entry.reg_addr;
                        ld_last     = 1'b1;
                        n_dual      = r_dual | i_entry.chip;
                        if (i_entry.store_en && r_mute_bits[MUTE_AW'(i_entry.voice)]) begin
                            ld_value = silence(i_entry.value);
                        end else begin
                            ld_value = i_entry.value;
                        end
                    end
                end
            end
            BK_SLOT0: begin
                // Emit slot 0 while fetching slot 1.
                load = 1'b1;
                if (r_cur_mute) begin
                    ld_value = silence(stored_level);
                end
            end
            BK_SLOT1: begin
                load        = 1'b1;
                ld_register = TL_BASE_SLOT1 + op_offset(r_cur_channel);
                ld_last     = 1'b1;
                if (r_cur_mute) begin
                    ld_value = silence(stored_level);
                end
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    assign o_pop = pop;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_strobe <= 1'b0;
            r_dual   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= load;
            r_dual   <= n_dual;
        end
    end

    // Level store with registered read port.
    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            r_level_mem[lvl_waddr] <= i_entry.value;
        end
        r_rd_data <= r_level_mem[rd_addr];
    end

    // Per-entry valid bits stand for the cleared store after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVEL_DEPTH; i++) begin
                r_level_valid[i] <= 1'b0;
            end
            r_rd_valid <= 1'b0;
        end else begin
            if (lvl_we) begin
                r_level_valid[lvl_waddr] <= 1'b1;
            end
            r_rd_valid <= r_level_valid[rd_addr];
        end
    end

    // Mute bits, one per voice.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VOICE_LIMIT; i++) begin
                r_mute_bits[i] <= 1'b0;
            end
        end else if (mute_we) begin
            r_mute_bits[MUTE_AW'(i_entry.voice)] <= i_entry.mute_flag;
        end
    end

    // Details of the mute change being replayed.
    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_cur_voice   <= i_entry.voice;
            r_cur_channel <= i_entry.channel;
            r_cur_chip    <= i_entry.chip;
            r_cur_mute    <= i_entry.mute_flag;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_chip     <= ld_chip;
            r_register <= ld_register;
            r_value    <= ld_value;
            r_last     <= ld_last;
            r_dual_out <= n_dual;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_chip        = r_chip;
    assign o_register    = r_register;
    assign o_value       = r_value;
    assign o_last        = r_last;
    assign o_dual_active = r_dual_out;

endmodule

FILE: hdl/opl_voice_mute_write_filter_top.sv
// ----------------------------------------------------------------------------
// opl_voice_mute_write_filter_top
// Register write filter in front of two FM synth chips with per-voice muting.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge where start is high and busy is low.
// A register write gives one result, strobed on o_strobe after it has passed
// the request queue and the result register; the back end takes one write per
// cycle unless a mute change holds it, so writes may be issued every cycle.
// A mute change for voices 0 to 17 gives two results (slot 0, then slot 1)
// on consecutive cycles and holds the back end through its slot 0 and slot 1
// states while the level store, with one write and one registered read port,
// is read once per slot. A two entry request queue sits between the front and
// the back; busy is high while it is full. Results are shown for exactly one
// cycle and cannot be held off, so they must be captured on the strobe.
// ----------------------------------------------------------------------------
module opl_voice_mute_write_filter_top import ovmw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_operation,
    input  logic               i_chip_select,
    input  logic [7:0]         i_register_address,
    input  logic [7:0]         i_write_value,
    input  logic [VOICE_W-1:0] i_voice_index,
    input  logic               i_mute_flag,
    output logic               o_strobe,
    output logic               o_out_chip,
    output logic [7:0]         o_out_register,
    output logic [7:0]         o_out_value,
    output logic               o_last,
    output logic               o_dual_active
);

    t_queue_status status;
    t_entry        push_entry;
    t_entry        head_entry;
    logic          push;
    logic          pop;

    // Request front end.
    ovmw_front u_front (
        .i_start            (start),
        .i_status           (status),
        .i_operation        (i_operation),
        .i_chip_select      (i_chip_select),
        .i_register_address (i_register_address),
        .i_write_value      (i_write_value),
        .i_voice_index      (i_voice_index),
        .i_mute_flag        (i_mute_flag),
        .o_busy             (busy),
        .o_push             (push),
        .o_entry            (push_entry)
    );

    // Request queue.
    ovmw_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (status)
    );

    // Execution back end.
    ovmw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (head_entry),
        .i_status      (status),
        .o_pop         (pop),
        .o_strobe      (o_strobe),
        .o_chip        (o_out_chip),
        .o_register    (o_out_register),
        .o_value       (o_out_value),
        .o_last        (o_last),
        .o_dual_active (o_dual_active)
    );

    // A first result of a mute change is always followed by its second.
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe && o_last)
        else $error("mute change result pair broken");

    // The second result targets the slot 1 register of the same chip.
    a_pair_register: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_out_chip == $past(o_out_chip) &&
            o_out_register == $past(o_out_register) + 8'd3)
        else $error("slot 1 result does not match slot 0 result");

    // The queue never pops while empty nor pushes while full.
    a_queue_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && status.empty) && !(push && status.full))
        else $error("request queue overrun or underrun");

endmodule

FILE: tb/sv/tb_opl_voice_mute_write_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_opl_voice_mute_write_filter_top
// Self-checking bench for the voice mute write filter.
// ----------------------------------------------------------------------------
// A directed run covers the address extremes, muting and unmuting, voices
// that were never written, out-of-range voices and the dual-chip flag.
// Several hundred random requests follow, mostly total-level writes and mute
// changes. A level store model inside the scoreboard predicts every
// forwarded write, and each strobed result is compared with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
import ovmw_pkg::*;

// One forwarded write as predicted for the chip bus.
typedef struct {
    logic       chip;
    logic [7:0] addr;
    logic [7:0] value;
    logic       last;
    logic       dual;
} t_fwd_write;

class level_scoreboard;
    t_fwd_write fwd_q[$];
    logic [7:0] level_mem[LEVEL_DEPTH];
    logic       mute_mem[VOICE_LIMIT];
    logic       dual_seen;
    int         errors;
    int         checked;
    int         n_writes;
    int         n_mutes;
    int         n_ignored;

    function new();
        foreach (level_mem[i]) level_mem[i] = 8'h00;
        foreach (mute_mem[i]) mute_mem[i] = 1'b0;
        dual_seen = 1'b0;
        errors    = 0;
        checked   = 0;
        n_writes  = 0;
        n_mutes   = 0;
        n_ignored = 0;
    endfunction

    // Total-level register address of a channel and slot.
    static function logic [7:0] tl_address(int slot, int ch);
        byte unsigned tbl[9];
        tbl = '{0, 1, 2, 8, 9, 10, 16, 17, 18};
        return (slot != 0 ? TL_BASE_SLOT1 : TL_BASE_SLOT0) + tbl[ch];
    endfunction

    // Finds the channel and slot of a total-level address, if it is one.
    function bit find_level(logic [7:0] addr, output int ch, output int slot);
        ch   = 0;
        slot = 0;
        for (int c = 0; c < CHANNELS_PER_CHIP; c++) begin
            for (int s = 0; s < 2; s++) begin
                if (addr == tl_address(s, c)) begin
                    ch   = c;
                    slot = s;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function logic [7:0] quieten(logic [7:0] v);
        return (v & KEEP_MASK) | SILENT_BITS;
    endfunction

    function int pending();
        return fwd_q.size();
    endfunction

    // Appends one predicted write behind those already waiting.
    function void add_expected(t_fwd_write w);
        fwd_q.insert(fwd_q.size(), w);
    endfunction

    // Updates the model with an accepted request and queues its writes.
    function void note_request(t_op op, logic chip, logic [7:0] addr,
                               logic [7:0] val, logic [VOICE_W-1:0] voice,
                               logic mute);
        t_fwd_write w;
        int         ch;
        int         slot;
        int         v;
        logic [7:0] raw;
        if (op == OP_WRITE) begin
            n_writes++;
            if (chip) dual_seen = 1'b1;
            w.value = val;
            if (find_level(addr, ch, slot)) begin
                v = int'(chip) * CHANNELS_PER_CHIP + ch;
                level_mem[v * 2 + slot] = val;
                if (mute_mem[v]) w.value = quieten(val);
            end
            w.chip = chip;
            w.addr = addr;
            w.last = 1'b1;
            w.dual = dual_seen;
            add_expected(w);
        end else if (int'(voice) >= VOICE_LIMIT) begin
            // Voices beyond the second chip are dropped without a trace.
            n_ignored++;
        end else begin
            n_mutes++;
            v = int'(voice);
            mute_mem[v] = mute;
            for (int s = 0; s < 2; s++) begin
                raw     = level_mem[v * 2 + s];
                w.chip  = (v >= CHANNELS_PER_CHIP);
                w.addr  = tl_address(s, v % CHANNELS_PER_CHIP);
                w.value = mute ? quieten(raw) : raw;
                w.last  = (s == 1);
                w.dual  = dual_seen;
                add_expected(w);
            end
        end
    endfunction

    task report_mismatch(string what);
        errors++;
        $display("MISMATCH: %s", what);
    endtask

    // Compares one strobed result with the oldest predicted write.
    task check_result(logic chip, logic [7:0] addr, logic [7:0] val,
                      logic last, logic dual);
        t_fwd_write w;
        if (fwd_q.size() == 0) begin
            report_mismatch($sformatf("unexpected write chip %0b reg %02h val %02h",
                                      chip, addr, val));
            return;
        end
        w = fwd_q.pop_front();
        checked++;
        if (chip !== w.chip)
            report_mismatch($sformatf("chip %b, expected %b", chip, w.chip));
        if (addr !== w.addr)
            report_mismatch($sformatf("register %02h, expected %02h", addr, w.addr));
        if (val !== w.value)
            report_mismatch($sformatf("value %02h, expected %02h (reg %02h)",
                                      val, w.value, w.addr));
        if (last !== w.last)
            report_mismatch($sformatf("last %b, expected %b", last, w.last));
        if (dual !== w.dual)
            report_mismatch($sformatf("dual flag %b, expected %b", dual, w.dual));
    endtask
endclass

module tb_opl_voice_mute_write_filter_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 750;

    logic               i_clk              = 1'b0;
    logic               i_rst_n            = 1'b0;
    logic               start              = 1'b0;
    logic               busy;
    logic               i_operation        = OP_WRITE;
    logic               i_chip_select      = 1'b0;
    logic [7:0]         i_register_address = 8'h00;
    logic [7:0]         i_write_value      = 8'h00;
    logic [VOICE_W-1:0] i_voice_index      = '0;
    logic               i_mute_flag        = 1'b0;
    logic               o_strobe;
    logic               o_out_chip;
    logic [7:0]         o_out_register;
    logic [7:0]         o_out_value;
    logic               o_last;
    logic               o_dual_active;

    level_scoreboard sb;
    int              cycle_count = 0;
    bit              no_idle     = 1'b0;

    opl_voice_mute_write_filter_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_operation        (i_operation),
        .i_chip_select      (i_chip_select),
        .i_register_address (i_register_address),
        .i_write_value      (i_write_value),
        .i_voice_index      (i_voice_index),
        .i_mute_flag        (i_mute_flag),
        .o_strobe           (o_strobe),
        .o_out_chip         (o_out_chip),
        .o_out_register     (o_out_register),
        .o_out_value        (o_out_value),
        .o_last             (o_last),
        .o_dual_active      (o_dual_active)
    );

    always #1 i_clk = ~i_clk;

    // Results are checked and accepted requests noted on the same edge.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (o_strobe === 1'b1)
                sb.check_result(o_out_chip, o_out_register, o_out_value,
                                o_last, o_dual_active);
            if (start && busy === 1'b0)
                sb.note_request(t_op'(i_operation), i_chip_select,
                                i_register_address, i_write_value,
                                i_voice_index, i_mute_flag);
        end
    end

    // Watchdog against a hung handshake.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    // Presents one request after a random gap (none while no_idle is set) and holds it until taken.
    task automatic send_item(input logic op, input logic chip, input logic [7:0] addr,
                             input logic [7:0] val, input logic [VOICE_W-1:0] voice,
                             input logic mute);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start              <= 1'b1;
        i_operation        <= op;
        i_chip_select      <= chip;
        i_register_address <= addr;
        i_write_value      <= val;
        i_voice_index      <= voice;
        i_mute_flag        <= mute;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Register write; the mute fields carry noise.
    task automatic write_req(input logic chip, input logic [7:0] addr,
                             input logic [7:0] val);
        send_item(OP_WRITE, chip, addr, val, VOICE_W'($urandom), 1'($urandom));
    endtask

    // Mute change; the write fields carry noise.
    task automatic mute_req(input logic [VOICE_W-1:0] voice, input logic mute);
        send_item(OP_MUTE, 1'($urandom), 8'($urandom), 8'($urandom), voice, mute);
    endtask

    // Stops sending until every predicted write has been seen.
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() > 0);
    endtask

    initial begin
        int         kind;
        logic [7:0] r_addr;
        sb = new();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: address extremes, then muting around voice 0.
        write_req(1'b0, 8'h00, 8'h00);
        write_req(1'b0, 8'hFF, 8'hFF);
        write_req(1'b0, 8'h40, 8'hA5);
        write_req(1'b0, 8'h43, 8'hFF);
        mute_req(5'd0, 1'b1);
        write_req(1'b0, 8'h40, 8'h12);
        mute_req(5'd0, 1'b0);
        // Never-written voices, on both chips, before chip 1 is used.
        mute_req(5'd8, 1'b1);
        mute_req(5'd17, 1'b1);
        // Voices past the last chip give nothing.
        mute_req(5'd18, 1'b1);
        mute_req(5'd31, 1'b0);
        // First use of chip 1 raises the dual flag.
        write_req(1'b1, 8'h55, 8'hC0);
        write_req(1'b1, 8'h52, 8'h00);
        mute_req(5'd17, 1'b0);
        write_req(1'b1, 8'h00, 8'h5A);
        // Addresses just outside the total-level window.
        write_req(1'b0, 8'h3F, 8'h33);
        write_req(1'b0, 8'h56, 8'h77);
        mute_req(5'd9, 1'b1);
        write_req(1'b1, 8'h40, 8'h80);
        mute_req(5'd9, 1'b0);

        // Random traffic, mostly level writes and mute changes.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_idle = ((i / 100) % 3 == 1);
            if (i == RANDOM_ITEMS / 2) drain();
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                r_addr = sb.tl_address($urandom_range(0, 1), $urandom_range(0, 8));
                write_req(1'($urandom), r_addr, 8'($urandom));
            end else if (kind < 70) begin
                write_req(1'($urandom), 8'($urandom), 8'($urandom));
            end else if (kind < 93) begin
                mute_req(VOICE_W'($urandom_range(0, VOICE_LIMIT - 1)), 1'($urandom));
            end else begin
                mute_req(VOICE_W'($urandom_range(VOICE_LIMIT, 31)), 1'($urandom));
            end
        end

        // Let the pipeline empty, then wait for strays.
        drain();
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d writes never arrived", sb.pending()));

        $display("Covered %0d register writes, %0d mute changes and %0d ignored voices.",
                 sb.n_writes, sb.n_mutes, sb.n_ignored);
        $display("Compared %0d forwarded writes, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
